@@ hw/rtl/hll_pkg.sv @@
`default_nettype none

package hll_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 9;
  localparam int unsigned BLK_W      = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = 1'd1;

  localparam logic [CFG_DATA_W-1:0] IMAGE_SIZE_RESET = 8'd128;
  localparam logic [CFG_DATA_W-1:0] MAX_VALUE_RESET  = 8'd255;

  typedef struct packed {
    logic wr;
    logic rd;
    logic row_end;
    logic image_end;
  } hll_issue_t;

endpackage

`default_nettype wire

@@ hw/rtl/hll_ram.sv @@
`default_nettype none

module hll_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hll_scan.sv @@
`default_nettype none

module hll_scan #(
  parameter int unsigned MAX_WIDTH = 128,
  parameter int unsigned AW        = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [hll_pkg::PIX_W-1:0]       pixel,
  input  logic [hll_pkg::CFG_DATA_W-1:0]  image_size,
  output hll_pkg::hll_issue_t             issue,
  output logic [AW-1:0]                   addr,
  output logic [hll_pkg::SUM_W-1:0]       pair_total
);

  import hll_pkg::*;

  localparam int unsigned PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);
  localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);

  logic [PW-1:0]    col;
  logic [PW-1:0]    row;
  logic [PW-1:0]    col_next;
  logic [PW-1:0]    row_next;
  logic [PIX_W-1:0] first_pix;
  logic [SW-1:0]    size_eff;
  logic [SW-1:0]    lim;
  logic [SW-1:0]    last;
  logic [SW-1:0]    half_last;
  logic [SW-1:0]    col_ext;
  logic [SW-1:0]    row_ext;
  logic             in_block;
  logic             last_pair_col;
  logic             last_pair_row;

  always_comb begin
    if (32'(image_size) > MAX_W32) begin
      size_eff = SW'(MAX_WIDTH);
    end else if (image_size < 8'd2) begin
      size_eff = SW'(2);
    end else begin
      size_eff = SW'(image_size);
    end
  end

  assign lim       = {size_eff[SW-1:1], 1'b0};
  assign last      = size_eff - SW'(1);
  assign half_last = (size_eff >> 1) - SW'(1);
  assign col_ext   = SW'(col);
  assign row_ext   = SW'(row);
  assign in_block  = (col_ext < lim) && (row_ext < lim);

  assign last_pair_col = (SW'(col >> 1) == half_last);
  assign last_pair_row = (SW'(row >> 1) == half_last);

  assign issue.wr        = accept && in_block && col[0] && !row[0];
  assign issue.rd        = accept && in_block && col[0] && row[0];
  assign issue.row_end   = last_pair_col;
  assign issue.image_end = last_pair_col && last_pair_row;

  assign addr       = AW'(col >> 1);
  assign pair_total = {1'b0, first_pix} + {1'b0, pixel};

  always_comb begin
    col_next = col;
    row_next = row;
    if (col_ext >= last) begin
      col_next = '0;
      row_next = (row_ext >= last) ? '0 : row + PW'(1);
    end else begin
      col_next = col + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      first_pix <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      if (in_block && !col[0]) begin
        first_pix <= pixel;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/haar_ll_downsample_2x2.sv @@
// Output: the pixel that completes a block is registered into stage one, then into the output register.
// Throughput: one pixel per cycle while in_stall is low; the line store has one port, and a row never reads
// a slot in the same cycle that it writes one.
// Reset: positions, pair register and handshake state clear; image_size returns to 128 and
// max_value to 255. The line store is not cleared and needs no clearing pass.
`default_nettype none

module haar_ll_downsample_2x2 #(
  parameter int unsigned MAX_WIDTH = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hll_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hll_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hll_pkg::PIX_W-1:0]      pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hll_pkg::PIX_W-1:0]      ll_value,
  output logic                           row_end,
  output logic                           image_end
);

  import hll_pkg::*;

  localparam int unsigned LD = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int unsigned AW = (LD > 1) ? $clog2(LD) : 1;

  logic [CFG_DATA_W-1:0] image_size;
  logic [CFG_DATA_W-1:0] max_value;

  logic             accept;
  logic             out_free;
  hll_issue_t       issue;
  logic [AW-1:0]    addr;
  logic [SUM_W-1:0] pair_total;
  logic [SUM_W-1:0] line_rdata;

  logic             s1_valid;
  logic [SUM_W-1:0] s1_sum;
  logic             s1_row_end;
  logic             s1_image_end;

  logic [BLK_W-1:0] blk_sum;
  logic [SUM_W-1:0] halved;
  logic [PIX_W-1:0] clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= IMAGE_SIZE_RESET;
      max_value  <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_SIZE: begin
          image_size <= cfg_data;
        end
        REG_MAX_VALUE: begin
          max_value <= cfg_data;
        end
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  hll_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixel      (pixel),
    .image_size (image_size),
    .issue      (issue),
    .addr       (addr),
    .pair_total (pair_total)
  );

  hll_ram #(
    .WIDTH (SUM_W),
    .DEPTH (LD),
    .AW    (AW)
  ) u_line_store (
    .clk   (clk),
    .we    (issue.wr),
    .re    (issue.rd),
    .addr  (addr),
    .wdata (pair_total),
    .rdata (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue.rd) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.rd) begin
      s1_sum       <= pair_total;
      s1_row_end   <= issue.row_end;
      s1_image_end <= issue.image_end;
    end
  end

  assign blk_sum = {1'b0, line_rdata} + {1'b0, s1_sum};
  assign halved  = blk_sum[BLK_W-1:1];
  assign clamped = (halved > {1'b0, max_value}) ? max_value : halved[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      ll_value  <= clamped;
      row_end   <= s1_row_end;
      image_end <= s1_image_end;
    end
  end

endmodule

`default_nettype wire
